/* hdl/frdf_pkg.sv */
// Package for the flood relay duplicate filter.
// Holds the message template, field widths, the verdict codes and the queue record type.
// Has no dependencies. Every other file in hdl uses it.
package frdf_pkg;

  // Table of last sequence numbers, one entry per source.
  localparam int TABLE_DEPTH = 16;

  // Message layout.
  localparam int MSG_LEN    = 34;
  localparam int SRC_OFF    = 4;
  localparam int SEQ_OFF    = 15;
  localparam int NUM_DIGITS = 6;
  localparam int POS_W      = 6;
  localparam int NUM_W      = 20;
  localparam int BYTE_W     = 8;

  // Front-to-back queue.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Marker in the template for a position that must hold a decimal digit.
  localparam logic [BYTE_W-1:0] DIGIT_MARK = 8'h23;

  localparam logic [BYTE_W-1:0] MSG_TEMPLATE [MSG_LEN] = '{
    8'h53, 8'h72, 8'h63, 8'h3d,
    DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, 8'h3b,
    8'h53, 8'h65, 8'h71, 8'h3d,
    DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, 8'h3b,
    8'h50, 8'h61, 8'h79, 8'h3d,
    DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, DIGIT_MARK, 8'h3b,
    8'h0a
  };

  typedef enum logic [2:0] {
    V_NEW_SRC   = 3'd0,
    V_NEWER_SEQ = 3'd1,
    V_DUPLICATE = 3'd2,
    V_OWN_NODE  = 3'd3,
    V_MALFORMED = 3'd4,
    V_FULL_FWD  = 3'd5
  } verdict_e;

  // One finished message handed from the parser to the table stage.
  typedef struct packed {
    logic             well_formed;
    logic [NUM_W-1:0] src;
    logic [NUM_W-1:0] seq;
  } msg_rec_t;

  // True when byte b is allowed at message position pos.
  function automatic logic byte_fits(input logic [POS_W-1:0] pos,
                                     input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    logic              fits;
    t    = '0;
    fits = 1'b0;
    if (int'(pos) < MSG_LEN) begin
      t = MSG_TEMPLATE[pos];
      if (t == DIGIT_MARK) begin
        fits = (b >= 8'h30) && (b <= 8'h39);
      end else begin
        fits = (b == t);
      end
    end
    return fits;
  endfunction

  // acc * 10 + digit, kept to NUM_W bits.
  function automatic logic [NUM_W-1:0] dec_shift(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] digit);
    return {acc[NUM_W-4:0], 3'b000} + {acc[NUM_W-2:0], 1'b0}
           + {{(NUM_W-4){1'b0}}, digit};
  endfunction

endpackage

/* hdl/flood_relay_duplicate_filter_top.sv */
// Top level of the flood relay duplicate filter: parser, record queue and table stage.
// Depends on frdf_pkg, frdf_parser, frdf_fifo and frdf_table.
//
//  channel  | direction | tdata                          | tuser / tlast
//  s_axis   | in        | [7:0] msg_byte                 | tlast = last_byte
//  m_axis   | out       | [19:0] source_id, [39:20] seq  | tuser [0] forward, [3:1] verdict
//  cfg      | in        | [19:0] own_node_id             | cfg_we_i write strobe
//
// One byte is accepted per cycle while s_axis_tready is high. The record enters the queue on the
// edge that takes the final byte, and the table stage then registers the verdict once its output
// register is free or being read; results drain one per cycle while m_axis_tready is high.
// The table compares all 16 entries in parallel, so back-to-back messages need no gap.
// Reset clears the parse state, the queue, the output valid flag and every table valid mark.
// A stalled output stops the table stage; the two-entry queue then fills and drops s_axis_tready.
module flood_relay_duplicate_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,   // [19:0] own_node_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] msg_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [19:0] source_id, [39:20] sequence_res
  output logic [3:0]  m_axis_tuser   // [0] forward, [3:1] verdict
);

  logic [frdf_pkg::NUM_W-1:0] own_id_q;
  logic                       fifo_full, fifo_not_empty;
  logic                       push, pop;
  frdf_pkg::msg_rec_t         wr_rec, rd_rec;

  // Hold this node's id.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_we_i) begin
      own_id_q <= cfg_wdata_i;
    end
  end

  frdf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .fifo_full_i  (fifo_full),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .rec_o        (wr_rec)
  );

  frdf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wr_rec_i    (wr_rec),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .not_empty_o (fifo_not_empty),
    .rd_rec_o    (rd_rec)
  );

  frdf_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (fifo_not_empty),
    .rec_i       (rd_rec),
    .own_id_i    (own_id_q),
    .out_ready_i (m_axis_tready),
    .rec_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* hdl/frdf_parser.sv */
// Front stage: checks the message format byte by byte and builds the decimal fields.
// Pushes one record per final byte into the queue. Depends on frdf_pkg.
module frdf_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [frdf_pkg::BYTE_W-1:0] byte_i,
  input  logic                        last_i,
  input  logic                        fifo_full_i,
  output logic                        byte_ready_o,
  output logic                        push_o,
  output frdf_pkg::msg_rec_t          rec_o
);

  logic [frdf_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       fmt_ok_q, fmt_ok_d;
  logic [frdf_pkg::NUM_W-1:0] id_acc_q, id_acc_d;
  logic [frdf_pkg::NUM_W-1:0] seq_acc_q, seq_acc_d;

  logic                       accept;
  logic                       ok;
  logic                       in_src, in_seq;
  logic [frdf_pkg::NUM_W-1:0] id_next, seq_next;
  logic                       complete;

  assign byte_ready_o = !fifo_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  // Check the byte against the template and fold digits into the accumulators.
  always_comb begin
    ok     = fmt_ok_q && frdf_pkg::byte_fits(pos_q, byte_i);
    in_src = (int'(pos_q) >= frdf_pkg::SRC_OFF)
             && (int'(pos_q) < frdf_pkg::SRC_OFF + frdf_pkg::NUM_DIGITS);
    in_seq = (int'(pos_q) >= frdf_pkg::SEQ_OFF)
             && (int'(pos_q) < frdf_pkg::SEQ_OFF + frdf_pkg::NUM_DIGITS);
    id_next  = (ok && in_src) ? frdf_pkg::dec_shift(id_acc_q, byte_i[3:0]) : id_acc_q;
    seq_next = (ok && in_seq) ? frdf_pkg::dec_shift(seq_acc_q, byte_i[3:0]) : seq_acc_q;
    complete = ok && (int'(pos_q) == frdf_pkg::MSG_LEN - 1);
  end

  // Emit the record on the final byte; malformed messages report zero fields.
  always_comb begin
    push_o            = accept && last_i;
    rec_o.well_formed = complete;
    rec_o.src         = complete ? id_next : '0;
    rec_o.seq         = complete ? seq_next : '0;
  end

  // Advance the parse state, or clear it after the final byte.
  always_comb begin
    pos_d     = pos_q;
    fmt_ok_d  = fmt_ok_q;
    id_acc_d  = id_acc_q;
    seq_acc_d = seq_acc_q;
    if (accept) begin
      if (last_i) begin
        pos_d     = '0;
        fmt_ok_d  = 1'b1;
        id_acc_d  = '0;
        seq_acc_d = '0;
      end else begin
        fmt_ok_d  = ok;
        id_acc_d  = id_next;
        seq_acc_d = seq_next;
        if (pos_q != '1) begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fmt_ok_q  <= 1'b1;
      id_acc_q  <= '0;
      seq_acc_q <= '0;
    end else begin
      pos_q     <= pos_d;
      fmt_ok_q  <= fmt_ok_d;
      id_acc_q  <= id_acc_d;
      seq_acc_q <= seq_acc_d;
    end
  end

endmodule

/* hdl/frdf_fifo.sv */
// Short queue of message records between the parser and the table stage.
// Depth comes from frdf_pkg::FIFO_DEPTH. Depends on frdf_pkg.
module frdf_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  frdf_pkg::msg_rec_t wr_rec_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               not_empty_o,
  output frdf_pkg::msg_rec_t rd_rec_o
);

  frdf_pkg::msg_rec_t              slot_q [frdf_pkg::FIFO_DEPTH];
  logic [frdf_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [frdf_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [frdf_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o      = (count_q == frdf_pkg::FIFO_CNT_W'(frdf_pkg::FIFO_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign rd_rec_o    = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Advance pointers with wrap and track the fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == frdf_pkg::FIFO_PTR_W'(frdf_pkg::FIFO_DEPTH - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == frdf_pkg::FIFO_PTR_W'(frdf_pkg::FIFO_DEPTH - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wr_rec_i;
    end
  end

endmodule

/* hdl/frdf_table.sv */
// Back stage: looks up the source in the sequence table, updates it and registers the verdict.
// Compares all entries at once; one record per cycle unless output stalls. Depends on frdf_pkg.
module frdf_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rec_valid_i,
  input  frdf_pkg::msg_rec_t          rec_i,
  input  logic [frdf_pkg::NUM_W-1:0]  own_id_i,
  input  logic                        out_ready_i,
  output logic                        rec_pop_o,
  output logic                        out_valid_o,
  output logic [3:0]                  out_user_o,
  output logic [2*frdf_pkg::NUM_W-1:0] out_data_o
);

  localparam int D = frdf_pkg::TABLE_DEPTH;

  logic [D-1:0]               valid_q;
  logic [frdf_pkg::NUM_W-1:0] src_q [D];
  logic [frdf_pkg::NUM_W-1:0] seq_q [D];

  logic                       out_valid_q;
  logic [3:0]                 out_user_q;
  logic [2*frdf_pkg::NUM_W-1:0] out_data_q;

  logic                       take;
  logic [D-1:0]               hit, first_hit, free, first_free;
  logic [frdf_pkg::NUM_W-1:0] hit_seq;
  logic                       is_own, newer;
  frdf_pkg::verdict_e         verdict;
  logic                       fwd;
  logic                       do_update, do_insert;

  assign take      = rec_valid_i && (!out_valid_q || out_ready_i);
  assign rec_pop_o = take;

  // Match every entry at once and pick the lowest hit and lowest free entry.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      hit[i]  = valid_q[i] && (src_q[i] == rec_i.src);
      free[i] = !valid_q[i];
    end
    first_hit  = hit & (~hit + 1'b1);
    first_free = free & (~free + 1'b1);
    hit_seq    = '0;
    for (int i = 0; i < D; i++) begin
      hit_seq = hit_seq | ({frdf_pkg::NUM_W{first_hit[i]}} & seq_q[i]);
    end
  end

  // Decide the verdict.
  always_comb begin
    is_own    = (rec_i.src == own_id_i);
    newer     = (hit_seq < rec_i.seq);
    do_update = 1'b0;
    do_insert = 1'b0;
    if (!rec_i.well_formed) begin
      verdict = frdf_pkg::V_MALFORMED;
    end else if (is_own) begin
      verdict = frdf_pkg::V_OWN_NODE;
    end else if (hit != '0) begin
      if (newer) begin
        verdict   = frdf_pkg::V_NEWER_SEQ;
        do_update = 1'b1;
      end else begin
        verdict = frdf_pkg::V_DUPLICATE;
      end
    end else if (free != '0) begin
      verdict   = frdf_pkg::V_NEW_SRC;
      do_insert = 1'b1;
    end else begin
      verdict = frdf_pkg::V_FULL_FWD;
    end
    fwd = (verdict == frdf_pkg::V_NEW_SRC) || (verdict == frdf_pkg::V_NEWER_SEQ)
          || (verdict == frdf_pkg::V_FULL_FWD);
  end

  // Mark entries valid as new sources arrive.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (take && do_insert) begin
      valid_q <= valid_q | first_free;
    end
  end

  // Write source and sequence into the chosen entry.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      if (take && do_insert && first_free[i]) begin
        src_q[i] <= rec_i.src;
        seq_q[i] <= rec_i.seq;
      end else if (take && do_update && first_hit[i]) begin
        seq_q[i] <= rec_i.seq;
      end
    end
  end

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_user_q <= {verdict, fwd};
      out_data_q <= {rec_i.seq, rec_i.src};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/frdf_checker.sv */
// Port-level checks for the flood relay duplicate filter, bound to the top level.
// Depends on frdf_pkg and flood_relay_duplicate_filter_top.
module frdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  logic [2:0] vcode;
  assign vcode = m_axis_tuser[3:1];

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                         && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Forward is set exactly for the relayed verdicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] == ((vcode == frdf_pkg::V_NEW_SRC)
                                          || (vcode == frdf_pkg::V_NEWER_SEQ)
                                          || (vcode == frdf_pkg::V_FULL_FWD)))
    else $error("forward flag disagrees with verdict");

  // A malformed message reports zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (vcode == frdf_pkg::V_MALFORMED) |-> m_axis_tdata == '0)
    else $error("malformed message reported nonzero fields");

  // A final byte taken with the output idle and ready is followed by a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid && !$past(s_axis_tlast)
    && $past(!s_axis_tvalid) && m_axis_tready
    |-> ##2 m_axis_tvalid || $past(m_axis_tvalid))
    else $error("result missing after final byte");

endmodule

bind flood_relay_duplicate_filter_top frdf_checker u_frdf_checker (.*);
